/* hw/rtl/hsh_pkg.sv */
// Shared types, constants and the sine table for the hillshade block.
// No dependencies; every other RTL file but hsh_if imports this package.

package hsh_pkg;

  // Angle encoding: 1/128 degree, a full turn is 46080 units
  localparam int TURN_ANG    = 46080;
  localparam int HALF_ANG    = 23040;
  localparam int QUARTER_ANG = 11520;
  localparam int ANG_W       = 16;

  // Sine table size and derived index widths
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
  localparam int Q_W   = $clog2(SINE_TABLE_ENTRIES + 1);

  // Table index = round(angle * N / 46080); 46080 = 45 << 10
  localparam int SCALE_SH = 10;
  localparam longint unsigned NUM_MAX =
    longint'(TURN_ANG - 1) * longint'(SINE_TABLE_ENTRIES) + longint'(HALF_ANG);
  localparam int NUM_W = $clog2(NUM_MAX + 1);
  localparam int T_W   = NUM_W - SCALE_SH;
  // floor(t / 45) as (t * RCP_M) >> RCP_SH, exact for t below 3.6 million
  localparam int RCP_M   = 2982617;
  localparam int RCP_M_W = 22;
  localparam int RCP_SH  = 27;
  localparam int RCP_W   = T_W + RCP_M_W + Q_W;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_AZIMUTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_ZENITH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHADE_GAIN  = 2'd2;
  localparam int CFG_DATA_W = 16;
  localparam logic [15:0] AZIMUTH_RST = 16'd40320;
  localparam logic [13:0] ZENITH_RST  = 14'd5760;
  localparam logic [15:0] GAIN_RST    = 16'd65280;

  // Result range
  localparam int SHADE_W = 17;
  localparam logic [SHADE_W:0] SHADE_MAX = 18'd65535;

  // Table lookups made per pixel
  localparam int LK_SIN_S = 0;
  localparam int LK_COS_S = 1;
  localparam int LK_SIN_Z = 2;
  localparam int LK_COS_Z = 3;
  localparam int LK_COS_D = 4;
  localparam int LK_N     = 5;

  // Pipeline stages, in order
  localparam int STG_RED = 0;  // reduce angles modulo a turn
  localparam int STG_ANG = 1;  // form the five lookup angles
  localparam int STG_NUM = 2;  // angle * N + half turn, >> 10
  localparam int STG_RCP = 3;  // reciprocal multiply by 1/45
  localparam int STG_ROM = 4;  // table read
  localparam int STG_MUL = 5;  // cos*cos and sin*sin
  localparam int STG_TRM = 6;  // align first term, times cos(diff)
  localparam int STG_SUM = 7;  // add the terms
  localparam int STG_ABS = 8;  // sign and magnitude
  localparam int STG_PP  = 9;  // gain partial products
  localparam int STG_RND = 10; // combine and round
  localparam int STG_OUT = 11; // saturate, apply sign, output register
  localparam int STG_N   = 12;

  typedef logic [ANG_W-1:0]          ang_t;
  typedef logic signed [16:0]        sine_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [STG_N-1:0]          stg_en_t;
  typedef sine_t                     sine_tab_t [SINE_TABLE_ENTRIES];

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Fold an angle below two turns back below one turn
  function automatic ang_t ang_wrap(logic [ANG_W:0] a);
    logic [ANG_W:0] r;
    r = (a >= (ANG_W+1)'(TURN_ANG)) ? a - (ANG_W+1)'(TURN_ANG) : a;
    return r[ANG_W-1:0];
  endfunction

  // Unsigned quotient by shift and subtract, for the table build
  function automatic longint unsigned udiv_u64(longint unsigned num,
                                               longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Full-turn sine table, Q1.15, from a Q30 Taylor series on a quarter wave
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint q;
    logic neg;
    int k;
    int n;
    for (k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      x = (64'd2 * PI_Q30 * longint'(k)) / SINE_TABLE_ENTRIES;
      neg = 1'b0;
      if (x > PI_Q30) begin
        x = x - PI_Q30;
        neg = 1'b1;
      end
      if (x > PI_Q30 / 2) begin
        x = PI_Q30 - x;
      end
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 9; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = udiv_u64(term, 64'((2 * n) * (2 * n + 1)));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 32768) begin
        q = 32768;
      end
      tab[k] = neg ? sine_t'(-q) : sine_t'(q);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* hw/rtl/hsh_if.sv */
// Stream channels of the hillshade block: pixel in, shade result out.
// Depends on nothing but plain logic types.

interface hsh_pix_if;
  logic        valid;
  logic        ready;
  logic [13:0] slope_angle;
  logic [15:0] aspect_angle;
  logic        frame_end;

  modport source (output valid, slope_angle, aspect_angle, frame_end, input ready);
  modport sink   (input valid, slope_angle, aspect_angle, frame_end, output ready);
endinterface

interface hsh_shade_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] shade_value;
  logic               frame_end_out;

  modport source (output valid, shade_value, frame_end_out, input ready);
  modport sink   (input valid, shade_value, frame_end_out, output ready);
endinterface

/* hw/rtl/hillshade_from_slope_aspect.sv */
// Top level of the hillshade block: config registers, stage control.
// Uses hsh_pkg, hsh_if, hsh_index, hsh_sine_rom and hsh_shade.
//
// Usage:
//   pix_i carries one pixel per transaction (slope, aspect, frame_end);
//   shade_o returns one shade value per pixel, in order, with frame_end
//   copied to frame_end_out. Both use valid/ready; a transaction happens
//   at a rising edge with valid and ready high.
//   The config port writes sun azimuth (0), sun zenith (1) and gain (2)
//   when cfg_we_i is high; index 3 is ignored. Write only while idle.
//   The accepting edge loads the first of 12 register stages; the
//   result is valid once the pixel has moved into the last stage.
//   Throughput is one pixel per cycle while shade_o.ready is high: a
//   12-stage pipeline, with the sine table read as a registered ROM in
//   one stage and the gain multiply split into two partial products over two stages.
//   Reset clears all stage valid bits and loads the register defaults
//   (315 deg azimuth, 45 deg zenith, gain 255.0).
//   When shade_o.ready is low, the output stage holds its result and
//   the stages behind it keep filling empty slots; pix_i.ready drops
//   only once every stage is occupied.

module hillshade_from_slope_aspect import hsh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hsh_pix_if.sink               pix_i,
  hsh_shade_if.source           shade_o
);

  logic [15:0] azimuth_q;
  logic [13:0] zenith_q;
  logic [15:0] gain_q;
  logic [STG_N-1:0] stg_vld_q;
  logic             fend_q [STG_N];
  stg_en_t          stg_en;
  idx_t             idx [LK_N];
  sine_t            sine [LK_N];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      azimuth_q <= AZIMUTH_RST;
      zenith_q  <= ZENITH_RST;
      gain_q    <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SUN_AZIMUTH: azimuth_q <= cfg_wdata_i;
        CFG_SUN_ZENITH:  zenith_q  <= cfg_wdata_i[13:0];
        CFG_SHADE_GAIN:  gain_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on
  always_comb begin
    stg_en[STG_N-1] = !stg_vld_q[STG_N-1] || shade_o.ready;
    for (int k = STG_N - 2; k >= 0; k--) begin
      stg_en[k] = !stg_vld_q[k] || stg_en[k+1];
    end
  end

  assign pix_i.ready = stg_en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
    end else begin
      if (stg_en[0]) begin
        stg_vld_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < STG_N; k++) begin
        if (stg_en[k]) begin
          stg_vld_q[k] <= stg_vld_q[k-1];
        end
      end
    end
  end

  // Frame marker rides along
  always_ff @(posedge clk_i) begin
    if (stg_en[0]) begin
      fend_q[0] <= pix_i.frame_end;
    end
    for (int k = 1; k < STG_N; k++) begin
      if (stg_en[k]) begin
        fend_q[k] <= fend_q[k-1];
      end
    end
  end

  hsh_index u_index (
    .clk_i          (clk_i),
    .stg_en_i       (stg_en),
    .slope_angle_i  (pix_i.slope_angle),
    .aspect_angle_i (pix_i.aspect_angle),
    .sun_azimuth_i  (azimuth_q),
    .sun_zenith_i   (zenith_q),
    .idx_o          (idx)
  );

  for (genvar g = 0; g < LK_N; g++) begin : g_rom
    hsh_sine_rom u_rom (
      .clk_i  (clk_i),
      .en_i   (stg_en[STG_ROM]),
      .idx_i  (idx[g]),
      .sine_o (sine[g])
    );
  end

  hsh_shade u_shade (
    .clk_i         (clk_i),
    .stg_en_i      (stg_en),
    .sine_i        (sine),
    .shade_gain_i  (gain_q),
    .shade_value_o (shade_o.shade_value)
  );

  assign shade_o.valid         = stg_vld_q[STG_N-1];
  assign shade_o.frame_end_out = fend_q[STG_N-1];

  // A receiver that takes the result frees the whole pipeline
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shade_o.ready |-> pix_i.ready)
    else $error("pipeline not ready although output is taken");

  // An accepted pixel occupies the first stage
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> stg_vld_q[0])
    else $error("accepted pixel lost at pipeline entry");

  // Saturation keeps the result symmetric
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shade_o.valid |-> (shade_o.shade_value != 17'h10000))
    else $error("shade value below saturation limit");

endmodule

/* hw/rtl/hsh_index.sv */
// Angle front end: reduces angles and maps them to sine table indexes.
// Uses hsh_pkg; occupies stages STG_RED through STG_RCP.

module hsh_index import hsh_pkg::*; (
  input  logic        clk_i,
  input  stg_en_t     stg_en_i,
  input  logic [13:0] slope_angle_i,
  input  logic [15:0] aspect_angle_i,
  input  logic [15:0] sun_azimuth_i,
  input  logic [13:0] sun_zenith_i,
  output idx_t        idx_o [LK_N]
);

  ang_t              slope_q, aspect_q, azimuth_q;
  ang_t              ang_q [LK_N];
  logic [T_W-1:0]    t_q   [LK_N];
  logic [RCP_W-1:0]  rcp_q [LK_N];
  logic signed [ANG_W+1:0] diff_cos;
  logic [ANG_W:0]    diff_wrap;

  // Register the slope; reduce aspect and azimuth modulo a turn
  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_RED]) begin
      slope_q   <= ANG_W'(slope_angle_i);
      aspect_q  <= ang_wrap({1'b0, aspect_angle_i});
      azimuth_q <= ang_wrap({1'b0, sun_azimuth_i});
    end
  end

  // azimuth - aspect + quarter turn, made non-negative; folded into one turn at the lookup stage
  always_comb begin
    diff_cos = $signed({2'b00, azimuth_q}) - $signed({2'b00, aspect_q})
             + (ANG_W+2)'(QUARTER_ANG);
    if (diff_cos < 0) begin
      diff_wrap = (ANG_W+1)'(diff_cos + (ANG_W+2)'(TURN_ANG));
    end else begin
      diff_wrap = (ANG_W+1)'(diff_cos);
    end
  end

  // Lookup angles; a cosine reads the sine a quarter turn on
  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_ANG]) begin
      ang_q[LK_SIN_S] <= slope_q;
      ang_q[LK_COS_S] <= ang_wrap({1'b0, slope_q} + (ANG_W+1)'(QUARTER_ANG));
      ang_q[LK_SIN_Z] <= ANG_W'(sun_zenith_i);
      ang_q[LK_COS_Z] <= ang_wrap((ANG_W+1)'(sun_zenith_i) + (ANG_W+1)'(QUARTER_ANG));
      ang_q[LK_COS_D] <= ang_wrap(diff_wrap);
    end
  end

  // Scale to table units: (angle * N + half turn) / 1024, then / 45
  for (genvar g = 0; g < LK_N; g++) begin : g_lk
    logic [NUM_W-1:0] num;

    assign num = NUM_W'(ang_q[g]) * NUM_W'(SINE_TABLE_ENTRIES) + NUM_W'(HALF_ANG);

    always_ff @(posedge clk_i) begin
      if (stg_en_i[STG_NUM]) begin
        t_q[g] <= num[NUM_W-1:SCALE_SH];
      end
      if (stg_en_i[STG_RCP]) begin
        rcp_q[g] <= RCP_W'(t_q[g]) * RCP_W'(RCP_M);
      end
    end

    // Nearest entry; rounding up to N wraps to entry 0
    logic [Q_W-1:0] q;
    assign q        = rcp_q[g][RCP_SH +: Q_W];
    assign idx_o[g] = (q == Q_W'(SINE_TABLE_ENTRIES)) ? '0 : q[IDX_W-1:0];
  end

endmodule

/* hw/rtl/hsh_sine_rom.sv */
// One read port on the constant sine table, registered read data.
// Uses hsh_pkg (SINE_TAB); read at stage STG_ROM.

module hsh_sine_rom import hsh_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  idx_t  idx_i,
  output sine_t sine_o
);

  sine_t sine_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= SINE_TAB[idx_i];
    end
  end

  assign sine_o = sine_q;

endmodule

/* hw/rtl/hsh_shade.sv */
// Shading arithmetic: trig products, gain, rounding and saturation.
// Uses hsh_pkg; occupies stages STG_MUL through STG_OUT.

module hsh_shade import hsh_pkg::*; (
  input  logic                     clk_i,
  input  stg_en_t                  stg_en_i,
  input  sine_t                    sine_i [LK_N],
  input  logic [15:0]              shade_gain_i,
  output logic signed [SHADE_W-1:0] shade_value_o
);

  logic signed [33:0] p_cc_q, p_ss_q;
  sine_t              cos_d_q;
  logic signed [47:0] t_cc_q, t_ssc_q;
  logic signed [50:0] ssc_full;
  logic signed [47:0] sum_q;
  logic               neg_q, neg_pp_q, neg_rnd_q;
  logic [46:0]        mag_q;
  logic [39:0]        pp_lo_q;
  logic [38:0]        pp_hi_q;
  logic [63:0]        full;
  logic [SHADE_W:0]   rnd_q;
  logic [SHADE_W:0]   sat;
  logic signed [SHADE_W-1:0] shade_q;

  // cos(s)cos(z) and sin(s)sin(z)
  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_MUL]) begin
      p_cc_q  <= 34'(sine_i[LK_COS_S]) * 34'(sine_i[LK_COS_Z]);
      p_ss_q  <= 34'(sine_i[LK_SIN_S]) * 34'(sine_i[LK_SIN_Z]);
      cos_d_q <= sine_i[LK_COS_D];
    end
  end

  // Both terms in Q45
  assign ssc_full = 51'(p_ss_q) * 51'(cos_d_q);

  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_TRM]) begin
      t_cc_q  <= 48'(p_cc_q) <<< 15;
      t_ssc_q <= ssc_full[47:0];
    end
    if (stg_en_i[STG_SUM]) begin
      sum_q <= t_cc_q + t_ssc_q;
    end
  end

  // Sign and magnitude; rounding is half away from zero
  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_ABS]) begin
      neg_q <= sum_q[47];
      mag_q <= sum_q[47] ? 47'(-sum_q) : 47'(sum_q);
    end
  end

  // Gain product split into two narrow partial products
  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_PP]) begin
      pp_lo_q  <= 40'(mag_q[23:0]) * 40'(shade_gain_i);
      pp_hi_q  <= 39'(mag_q[46:24]) * 39'(shade_gain_i);
      neg_pp_q <= neg_q;
    end
  end

  assign full = {1'b0, pp_hi_q, 24'd0} + 64'(pp_lo_q) + (64'd1 << 44);

  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_RND]) begin
      rnd_q     <= full[45 +: SHADE_W+1];
      neg_rnd_q <= neg_pp_q;
    end
  end

  // Saturate and restore the sign into the output register
  assign sat = (rnd_q > SHADE_MAX) ? SHADE_MAX : rnd_q;

  always_ff @(posedge clk_i) begin
    if (stg_en_i[STG_OUT]) begin
      shade_q <= neg_rnd_q ? -$signed(sat[SHADE_W-1:0]) : $signed(sat[SHADE_W-1:0]);
    end
  end

  assign shade_value_o = shade_q;

endmodule

/* tb/hsh_shade_checker.sv */
// Passive checker for the hillshade block: predicts each shade result and compares.
// Depends on hsh_pkg and the hsh_pix_if / hsh_shade_if channel interfaces.

module hsh_shade_checker import hsh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hsh_pix_if                    pix_mon,
  hsh_shade_if                  shade_mon,
  output int                    pending_o,
  output int                    errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL_TURN    = 46080;
  localparam longint HALF_TURN    = 23040;
  localparam longint RIGHT_ANGLE  = 11520;
  localparam longint TAB_N        = SINE_TABLE_ENTRIES;
  localparam longint unsigned PI_Q30_VAL = 64'd3373259426;
  localparam longint UNITY_Q15    = 32768;
  localparam longint SHADE_LIMIT  = 65535;

  typedef struct packed {
    logic signed [16:0] shade_value;
    logic               frame_end_out;
  } shade_exp_t;

  longint     sine_q15 [TAB_N];
  shade_exp_t expected_shades [$];

  // Shadow copies of the sun and gain registers
  logic [15:0] sun_az   = AZIMUTH_RST;
  logic [13:0] sun_zen  = ZENITH_RST;
  logic [15:0] gain_q88 = GAIN_RST;

  int n_err = 0;
  int n_pending = 0;

  assign errors_o  = n_err;
  assign pending_o = n_pending;

  // Taylor series sine on a quarter wave, Q30 in and out
  function automatic longint quarter_wave_q30(longint unsigned x);
    longint unsigned term;
    longint acc;
    int n;
    term = x;
    acc = longint'(x);
    for (n = 1; n <= 9; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'(unsigned'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 0 : acc;
  endfunction

  // Full-turn table, Q1.15, rounded half up
  initial begin : fill_sine_table
    longint unsigned x;
    longint q;
    bit neg;
    int k;
    for (k = 0; k < TAB_N; k++) begin
      x = (64'd2 * PI_Q30_VAL * longint'(k)) / longint'(TAB_N);
      neg = 1'b0;
      if (x > PI_Q30_VAL) begin
        x = x - PI_Q30_VAL;
        neg = 1'b1;
      end
      if (x > PI_Q30_VAL / 2) begin
        x = PI_Q30_VAL - x;
      end
      q = (quarter_wave_q30(x) + 64'sd16384) >>> 15;
      if (q > UNITY_Q15) begin
        q = UNITY_Q15;
      end
      sine_q15[k] = neg ? -q : q;
    end
  end

  // Nearest table entry for an angle in 1/128 degree
  function automatic longint lookup_sin(longint ang);
    longint a;
    a = ang % FULL_TURN;
    return sine_q15[((a * TAB_N + HALF_TURN) / FULL_TURN) % TAB_N];
  endfunction

  function automatic longint lookup_cos(longint ang);
    return lookup_sin((ang % FULL_TURN) + RIGHT_ANGLE);
  endfunction

  // Lambertian shade for one pixel under the current sun and gain
  function automatic logic signed [16:0] shade_for(longint slope, longint aspect);
    longint az;
    longint zen;
    longint diff;
    longint lit;
    longint prod;
    longint mag;
    longint val;
    az   = longint'(sun_az);
    zen  = longint'(sun_zen);
    diff = ((az % FULL_TURN) + FULL_TURN - (aspect % FULL_TURN)) % FULL_TURN;
    lit  = lookup_cos(slope) * lookup_cos(zen) * UNITY_Q15
         + lookup_sin(slope) * lookup_sin(zen) * lookup_cos(diff);
    prod = lit * longint'(gain_q88);
    mag  = (prod < 0) ? -prod : prod;
    // Q45 down to integer, half away from zero
    mag  = (mag + (64'sd1 <<< 44)) >>> 45;
    if (mag > SHADE_LIMIT) begin
      mag = SHADE_LIMIT;
    end
    val = (prod < 0) ? -mag : mag;
    return val[16:0];
  endfunction

  // Track register writes, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    shade_exp_t want;
    if (!rst_ni) begin
      sun_az   <= AZIMUTH_RST;
      sun_zen  <= ZENITH_RST;
      gain_q88 <= GAIN_RST;
      expected_shades.delete();
      n_pending = 0;
    end else begin
      if (pix_mon.valid && pix_mon.ready) begin
        want.shade_value   = shade_for(longint'(pix_mon.slope_angle),
                                       longint'(pix_mon.aspect_angle));
        want.frame_end_out = pix_mon.frame_end;
        expected_shades.push_back(want);
      end
      if (shade_mon.valid && shade_mon.ready) begin
        if (expected_shades.size() == 0) begin
          $error("shade transaction with no pixel outstanding: shade_value %0d",
                 shade_mon.shade_value);
          n_err++;
        end else begin
          want = expected_shades.pop_front();
          if (shade_mon.shade_value !== want.shade_value) begin
            $error("shade_value: expected %0d, got %0d",
                   want.shade_value, shade_mon.shade_value);
            n_err++;
          end
          if (shade_mon.frame_end_out !== want.frame_end_out) begin
            $error("frame_end_out: expected %0b, got %0b",
                   want.frame_end_out, shade_mon.frame_end_out);
            n_err++;
          end
        end
      end
      n_pending = expected_shades.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SUN_AZIMUTH: sun_az   <= cfg_wdata_i;
          CFG_SUN_ZENITH:  sun_zen  <= cfg_wdata_i[13:0];
          CFG_SHADE_GAIN:  gain_q88 <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb.sv */
// Top of the hillshade testbench: clock, reset, pixel stimulus, result sink, verdict.
// Depends on hsh_pkg, the channel interfaces, the block and hsh_shade_checker.

module tb import hsh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int STALL_LIMIT  = 1000;
  localparam int SQUEEZE_AT   = 150;
  localparam int SQUEEZE_LEN  = 100;
  localparam int RANDOM_BATCH = 58;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    errors;
  int                    tx_burst_left = 0;
  int                    rx_burst_left = 0;

  hsh_pix_if   pix ();
  hsh_shade_if shade ();

  hillshade_from_slope_aspect DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix),
    .shade_o     (shade)
  );

  hsh_shade_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_mon     (pix),
    .shade_mon   (shade),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Idle cycles before a transaction; occasional back-to-back runs
  function automatic int pick_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // One pixel transaction; valid stays up when the next gap is zero
  task automatic send_pixel(input logic [13:0] slope, input logic [15:0] aspect,
                            input logic fe);
    int gap;
    gap = pick_gap(tx_burst_left);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid        <= 1'b1;
    pix.slope_angle  <= slope;
    pix.aspect_angle <= aspect;
    pix.frame_end    <= fe;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  // Mostly in-range angles, some full-width to exercise wrap
  task automatic send_random_pixels(input int count);
    logic [13:0] s;
    logic [15:0] a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        s = 14'($urandom_range(0, 11520));
        a = 16'($urandom_range(0, 46080));
      end else begin
        s = 14'($urandom);
        a = 16'($urandom);
      end
      send_pixel(s, a, $urandom_range(0, 7) == 0);
    end
  endtask

  // Drop valid, then wait for every outstanding result plus pipeline slack
  task automatic finish_phase();
    pix.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (16) @(posedge clk_i);
  endtask

  // Write all three registers, plus a write to the unmapped index
  task automatic load_regs(input logic [15:0] az, input logic [15:0] zen,
                           input logic [15:0] gain);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SUN_AZIMUTH;
    cfg_wdata <= az;
    @(posedge clk_i);
    cfg_idx   <= CFG_SUN_ZENITH;
    cfg_wdata <= zen;
    @(posedge clk_i);
    cfg_idx   <= CFG_SHADE_GAIN;
    cfg_wdata <= gain;
    @(posedge clk_i);
    cfg_idx   <= CFG_UNMAPPED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Result sink with random back-pressure and one long hold-off
  initial begin : result_sink
    int hold;
    int taken;
    bit squeezed;
    taken = 0;
    squeezed = 1'b0;
    shade.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    shade.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (shade.valid && shade.ready) begin
        taken++;
        if (!squeezed && taken == SQUEEZE_AT) begin
          squeezed = 1'b1;
          hold = SQUEEZE_LEN;
        end else begin
          hold = pick_gap(rx_burst_left);
        end
        if (hold > 0) begin
          shade.ready <= 1'b0;
          repeat (hold) @(posedge clk_i);
          shade.ready <= 1'b1;
        end
      end
    end
  end

  // Ends the run if no transaction happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk_i);
      if ((pix.valid && pix.ready) || (shade.valid && shade.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end while (quiet < STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus phases and verdict
  initial begin : stimulus
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_SUN_AZIMUTH;
    cfg_wdata        <= '0;
    pix.valid        <= 1'b0;
    pix.slope_angle  <= '0;
    pix.aspect_angle <= '0;
    pix.frame_end    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: sun at 315 deg azimuth, 45 deg zenith, gain 255
    send_pixel(14'd0,     16'd0,     1'b0);  // flat ground
    send_pixel(14'd11520, 16'd40320, 1'b0);  // cliff facing the sun
    send_pixel(14'd11520, 16'd17280, 1'b1);  // cliff facing away, negative
    send_pixel(14'd5760,  16'd40320, 1'b0);  // normal points at the sun
    send_pixel(14'h3FFF,  16'd0,     1'b0);  // slope past vertical
    send_pixel(14'h3FFF,  16'hFFFF,  1'b1);  // all ones
    send_pixel(14'd11521, 16'd46079, 1'b0);
    send_pixel(14'd8191,  16'd46080, 1'b0);  // aspect of a full turn wraps
    send_pixel(14'd100,   16'd23040, 1'b0);
    send_pixel(14'd11520, 16'd0,     1'b0);
    send_pixel(14'd0,     16'hFFFF,  1'b1);
    send_pixel(14'd4096,  16'd32768, 1'b0);
    send_pixel(14'd11520, 16'd40321, 1'b0);
    send_pixel(14'd2,     16'd1,     1'b0);
    send_random_pixels(RANDOM_BATCH);
    finish_phase();

    // Everything zero: sun overhead, no gain
    load_regs(16'd0, 16'd0, 16'd0);
    send_random_pixels(RANDOM_BATCH);
    finish_phase();

    // Azimuth of a full turn, sun on the horizon, full gain
    load_regs(16'd46080, 16'd11520, 16'hFFFF);
    send_pixel(14'd11520, 16'd0,     1'b0);  // reaches the top of the range
    send_pixel(14'd11520, 16'd46080, 1'b1);
    send_pixel(14'd11520, 16'd23040, 1'b0);  // reaches the bottom
    send_pixel(14'd0,     16'd0,     1'b0);
    send_random_pixels(RANDOM_BATCH);
    finish_phase();

    // Full gain with the slope near the zenith: probes saturation
    load_regs(16'd0, 16'd5760, 16'hFFFF);
    send_pixel(14'd5700, 16'd0, 1'b0);
    send_pixel(14'd5740, 16'd0, 1'b0);
    send_pixel(14'd5760, 16'd0, 1'b1);
    send_pixel(14'd5780, 16'd0, 1'b0);
    send_pixel(14'd5820, 16'd0, 1'b0);
    send_random_pixels(RANDOM_BATCH);
    finish_phase();

    // All register bits set: azimuth wraps, zenith beyond 90 deg
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random_pixels(RANDOM_BATCH);
    finish_phase();

    // Arbitrary register contents
    load_regs(16'($urandom), 16'($urandom), 16'($urandom));
    send_random_pixels(RANDOM_BATCH);
    finish_phase();

    // Realistic sun position, unity gain
    load_regs(16'($urandom_range(0, 46080)), 16'($urandom_range(0, 11520)), 16'd256);
    send_random_pixels(RANDOM_BATCH);
    finish_phase();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/hsh_pkg.sv
hw/rtl/hsh_if.sv
hw/rtl/hsh_index.sv
hw/rtl/hsh_sine_rom.sv
hw/rtl/hsh_shade.sv
hw/rtl/hillshade_from_slope_aspect.sv
tb/hsh_shade_checker.sv
tb/tb.sv
